/* src/qtpr_pkg.sv */
// ----------------------------------------------------------------------------
// qtpr_pkg
// Shared types, constants and the CORDIC angle table of the tilt unit.
// ----------------------------------------------------------------------------
package qtpr_pkg;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int ITER_W            = 5;
   localparam int ADDR_W            = 5;

   localparam logic [2:0] REG_AXIS_SWAP = 3'd0;
   localparam logic [2:0] REG_INVERT_X  = 3'd1;
   localparam logic [2:0] REG_INVERT_Z  = 3'd2;
   localparam logic [2:0] REG_GAIN      = 3'd3;
   localparam logic [2:0] REG_DEADZONE  = 3'd4;

   typedef struct packed {
      logic               conn;
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
      logic signed [15:0] qw;
      logic signed [15:0] rx;
      logic signed [15:0] ry;
      logic signed [15:0] rz;
      logic signed [15:0] rw;
   } qtpr_job_type;

   typedef struct packed {
      logic        axis_swap;
      logic        invert_x;
      logic        invert_z;
      logic [9:0]  gain_q8;
      logic [14:0] deadzone_q8;
   } qtpr_cfg_type;

   // atan(2^-i) in degrees, Q.16
   function automatic logic signed [25:0] atan_q16(input logic [ITER_W-1:0] i);
      logic signed [25:0] v;
      case (i)
         5'd0:    v = 26'sd2949120;
         5'd1:    v = 26'sd1740967;
         5'd2:    v = 26'sd919879;
         5'd3:    v = 26'sd466945;
         5'd4:    v = 26'sd234379;
         5'd5:    v = 26'sd117304;
         5'd6:    v = 26'sd58666;
         5'd7:    v = 26'sd29335;
         5'd8:    v = 26'sd14668;
         5'd9:    v = 26'sd7334;
         5'd10:   v = 26'sd3667;
         5'd11:   v = 26'sd1833;
         5'd12:   v = 26'sd917;
         5'd13:   v = 26'sd458;
         5'd14:   v = 26'sd229;
         5'd15:   v = 26'sd115;
         5'd16:   v = 26'sd57;
         5'd17:   v = 26'sd29;
         5'd18:   v = 26'sd14;
         5'd19:   v = 26'sd7;
         5'd20:   v = 26'sd4;
         5'd21:   v = 26'sd2;
         5'd22:   v = 26'sd1;
         default: v = 26'sd0;
      endcase
      return v;
   endfunction

endpackage

/* src/qtpr_front.sv */
// ----------------------------------------------------------------------------
// qtpr_front
// Accepts requests, tracks the button edge and the level reference, and
// hands each request with its reference to the queue.
// ----------------------------------------------------------------------------
module qtpr_front import qtpr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [15:0]  req_quat_x,
   input  logic signed [15:0]  req_quat_y,
   input  logic signed [15:0]  req_quat_z,
   input  logic signed [15:0]  req_quat_w,
   input  logic                req_pad_connected,
   input  logic                req_touch_pressed,
   input  logic                req_recentre_request,
   output logic                job_valid,
   input  logic                job_ready,
   output qtpr_job_type        job
);

   logic signed [15:0] ref_x_ff, ref_y_ff, ref_z_ff, ref_w_ff;
   logic signed [15:0] ref_x_in, ref_y_in, ref_z_in, ref_w_in;
   logic               button_ff, button_in;
   logic               load;
   logic               accept;

   assign req_ready = job_ready;
   assign job_valid = req_valid;
   assign accept    = req_valid && job_ready;
   assign load      = (req_touch_pressed && !button_ff) || req_recentre_request;

   always_comb begin
      ref_x_in  = ref_x_ff;
      ref_y_in  = ref_y_ff;
      ref_z_in  = ref_z_ff;
      ref_w_in  = ref_w_ff;
      button_in = button_ff;
      if (accept && req_pad_connected) begin
         button_in = req_touch_pressed;
         if (load) begin
            ref_x_in = req_quat_x;
            ref_y_in = req_quat_y;
            ref_z_in = req_quat_z;
            ref_w_in = req_quat_w;
         end
      end
   end

   always_comb begin
      job.conn = req_pad_connected;
      job.qx   = req_quat_x;
      job.qy   = req_quat_y;
      job.qz   = req_quat_z;
      job.qw   = req_quat_w;
      job.rx   = load ? req_quat_x : ref_x_ff;
      job.ry   = load ? req_quat_y : ref_y_ff;
      job.rz   = load ? req_quat_z : ref_z_ff;
      job.rw   = load ? req_quat_w : ref_w_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff  <= 16'sd0;
         ref_y_ff  <= 16'sd0;
         ref_z_ff  <= 16'sd0;
         ref_w_ff  <= 16'sd16384;
         button_ff <= 1'b0;
      end else begin
         ref_x_ff  <= ref_x_in;
         ref_y_ff  <= ref_y_in;
         ref_z_ff  <= ref_z_in;
         ref_w_ff  <= ref_w_in;
         button_ff <= button_in;
      end
   end

endmodule

/* src/qtpr_queue.sv */
// ----------------------------------------------------------------------------
// qtpr_queue
// Two-entry request queue between the front and the back end.
// ----------------------------------------------------------------------------
module qtpr_queue import qtpr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  qtpr_job_type in_job,
   output logic         out_valid,
   input  logic         out_ready,
   output qtpr_job_type out_job
);

   qtpr_job_type mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_job   = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff)) else $error("queue pointers out of step");
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !out_ready) |=> (count_ff == 2'd2)) else $error("full queue lost a request");

endmodule

/* src/qtpr_back.sv */
// ----------------------------------------------------------------------------
// qtpr_back
// Sequenced arithmetic: quaternion product and angle operands on one shared
// multiplier, bit-serial square root, shared vectoring CORDIC, then
// deadzone, gain and sign into the output register.
// ----------------------------------------------------------------------------
module qtpr_back import qtpr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_ready,
   input  qtpr_job_type        job,
   input  qtpr_cfg_type        cfg,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [18:0]  rsp_pitch_out,
   output logic signed [18:0]  rsp_roll_out
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MULA  = 3'd1;
   localparam logic [2:0] ST_MULB  = 3'd2;
   localparam logic [2:0] ST_SQRT  = 3'd3;
   localparam logic [2:0] ST_CINIT = 3'd4;
   localparam logic [2:0] ST_CORD  = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   localparam logic [3:0] OP_QX = 4'd0;
   localparam logic [3:0] OP_QY = 4'd1;
   localparam logic [3:0] OP_QZ = 4'd2;
   localparam logic [3:0] OP_QW = 4'd3;
   localparam logic [3:0] OP_RX = 4'd4;
   localparam logic [3:0] OP_RY = 4'd5;
   localparam logic [3:0] OP_RZ = 4'd6;
   localparam logic [3:0] OP_RW = 4'd7;
   localparam logic [3:0] OP_X  = 4'd8;
   localparam logic [3:0] OP_Y  = 4'd9;
   localparam logic [3:0] OP_Z  = 4'd10;
   localparam logic [3:0] OP_W  = 4'd11;
   localparam logic [3:0] OP_S  = 4'd12;

   localparam logic [4:0] STEP_X    = 5'd3;
   localparam logic [4:0] STEP_Y    = 5'd7;
   localparam logic [4:0] STEP_Z    = 5'd11;
   localparam logic [4:0] STEP_W    = 5'd15;
   localparam logic [4:0] STEP_A    = 5'd17;
   localparam logic [4:0] STEP_B    = 5'd19;
   localparam logic [4:0] STEP_S    = 5'd21;
   localparam logic [4:0] LAST_STEP = 5'd22;

   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERATIONS - 1);

   localparam logic signed [60:0] ONE_Q28  = 61'sd268435456;
   localparam logic signed [60:0] ONE_Q56  = 61'sd72057594037927936;
   localparam logic signed [25:0] Z90      = 26'sd5898240;

   typedef struct packed {
      logic [3:0] a;
      logic [3:0] b;
      logic       neg;
   } uop_type;

   function automatic uop_type uop(input logic [4:0] step);
      uop_type u;
      case (step)
         5'd0:    u = '{OP_RW, OP_QX, 1'b0};
         5'd1:    u = '{OP_RX, OP_QW, 1'b1};
         5'd2:    u = '{OP_RY, OP_QZ, 1'b1};
         5'd3:    u = '{OP_RZ, OP_QY, 1'b0};
         5'd4:    u = '{OP_RW, OP_QY, 1'b0};
         5'd5:    u = '{OP_RX, OP_QZ, 1'b0};
         5'd6:    u = '{OP_RY, OP_QW, 1'b1};
         5'd7:    u = '{OP_RZ, OP_QX, 1'b1};
         5'd8:    u = '{OP_RW, OP_QZ, 1'b0};
         5'd9:    u = '{OP_RX, OP_QY, 1'b1};
         5'd10:   u = '{OP_RY, OP_QX, 1'b0};
         5'd11:   u = '{OP_RZ, OP_QW, 1'b1};
         5'd12:   u = '{OP_RW, OP_QW, 1'b0};
         5'd13:   u = '{OP_RX, OP_QX, 1'b0};
         5'd14:   u = '{OP_RY, OP_QY, 1'b0};
         5'd15:   u = '{OP_RZ, OP_QZ, 1'b0};
         5'd16:   u = '{OP_W, OP_X, 1'b0};
         5'd17:   u = '{OP_Y, OP_Z, 1'b0};
         5'd18:   u = '{OP_X, OP_X, 1'b1};
         5'd19:   u = '{OP_Y, OP_Y, 1'b1};
         5'd20:   u = '{OP_W, OP_Y, 1'b0};
         5'd21:   u = '{OP_Z, OP_X, 1'b1};
         default: u = '{OP_S, OP_S, 1'b1};
      endcase
      return u;
   endfunction

   function automatic logic signed [18:0] dead_gain(input logic signed [17:0] v,
                                                    input logic [14:0] d,
                                                    input logic [9:0] g,
                                                    input logic neg);
      logic signed [18:0] ve, de, vd;
      logic signed [29:0] p;
      logic signed [21:0] r;
      ve = {v[17], v};
      de = $signed({4'b0, d});
      if (ve > de) begin
         vd = ve - de;
      end else if (ve < -de) begin
         vd = ve + de;
      end else begin
         vd = '0;
      end
      p = {{11{vd[18]}}, vd} * $signed({20'b0, g});
      r = 22'((p + 30'sd128) >>> 8);
      if (neg) begin
         r = -r;
      end
      return r[18:0];
   endfunction

   logic [2:0]          state_ff, state_in;
   qtpr_job_type        job_ff, job_in;
   logic                zero_ff, zero_in;
   logic [4:0]          step_ff, step_in;
   logic signed [59:0]  prod_ff, prod_in;
   logic signed [59:0]  acc_ff, acc_in;
   logic signed [19:0]  px_ff, py_ff, pz_ff, pw_ff;
   logic signed [19:0]  px_in, py_in, pz_in, pw_in;
   logic signed [43:0]  a_ff, a_in, b_ff, b_in;
   logic signed [29:0]  s_ff, s_in;
   logic [57:0]         rad_ff, rad_in, root_ff, root_in, bit_ff, bit_in;
   logic signed [43:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic signed [25:0]  cz_ff, cz_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;
   logic                pass_ff, pass_in;
   logic signed [17:0]  roll_ff, roll_in, pitch_ff, pitch_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [18:0]  rsp_pitch_ff, rsp_pitch_in, rsp_roll_ff, rsp_roll_in;

   uop_type             u;
   logic signed [29:0]  opa, opb;
   logic signed [59:0]  sum;
   logic signed [60:0]  sum2;
   logic signed [59:0]  rnd;
   logic [57:0]         trial;
   logic signed [43:0]  yv, xv, dx, dy, cx_nx, cy_nx;
   logic signed [25:0]  cz_nx;
   logic signed [25:0]  zr;
   logic signed [17:0]  p_sel, r_sel;
   logic                out_free;

   function automatic logic signed [29:0] operand(input logic [3:0] code,
                                                  input qtpr_job_type j,
                                                  input logic signed [19:0] x,
                                                  input logic signed [19:0] y,
                                                  input logic signed [19:0] z,
                                                  input logic signed [19:0] w,
                                                  input logic signed [29:0] s);
      logic signed [29:0] v;
      case (code)
         OP_QX:   v = 30'(j.qx);
         OP_QY:   v = 30'(j.qy);
         OP_QZ:   v = 30'(j.qz);
         OP_QW:   v = 30'(j.qw);
         OP_RX:   v = 30'(j.rx);
         OP_RY:   v = 30'(j.ry);
         OP_RZ:   v = 30'(j.rz);
         OP_RW:   v = 30'(j.rw);
         OP_X:    v = 30'(x);
         OP_Y:    v = 30'(y);
         OP_Z:    v = 30'(z);
         OP_W:    v = 30'(w);
         default: v = s;
      endcase
      return v;
   endfunction

   assign job_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pitch_out = rsp_pitch_ff;
   assign rsp_roll_out  = rsp_roll_ff;

   always_comb begin
      u     = uop(step_ff);
      opa   = operand(u.a, job_ff, px_ff, py_ff, pz_ff, pw_ff, s_ff);
      opb   = operand(u.b, job_ff, px_ff, py_ff, pz_ff, pw_ff, s_ff);
      sum   = acc_ff + (u.neg ? -prod_ff : prod_ff);
      sum2  = {sum, 1'b0};
      rnd   = (sum + 60'sd8192) >>> 14;
      trial = root_ff + bit_ff;
      yv    = pass_ff ? 44'(s_ff) : a_ff;
      xv    = pass_ff ? $signed({14'b0, root_ff[29:0]}) : b_ff;
      dx    = cy_ff >>> iter_ff;
      dy    = cx_ff >>> iter_ff;
      if (!cy_ff[43]) begin
         cx_nx = cx_ff + dx;
         cy_nx = cy_ff - dy;
         cz_nx = cz_ff + atan_q16(iter_ff);
      end else begin
         cx_nx = cx_ff - dx;
         cy_nx = cy_ff + dy;
         cz_nx = cz_ff - atan_q16(iter_ff);
      end
      zr       = (cz_nx + 26'sd128) >>> 8;
      p_sel    = cfg.axis_swap ? roll_ff : pitch_ff;
      r_sel    = cfg.axis_swap ? pitch_ff : roll_ff;
      out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      zero_in      = zero_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      pw_in        = pw_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      s_in         = s_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      iter_in      = iter_ff;
      pass_in      = pass_ff;
      roll_in      = roll_ff;
      pitch_in     = pitch_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pitch_in = rsp_pitch_ff;
      rsp_roll_in  = rsp_roll_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_in  = job;
               zero_in = !job.conn;
               step_in = 5'd0;
               acc_in  = '0;
               state_in = job.conn ? ST_MULA : ST_FIN;
            end
         end
         ST_MULA: begin
            prod_in  = opa * opb;
            state_in = ST_MULB;
         end
         ST_MULB: begin
            acc_in   = sum;
            step_in  = step_ff + 5'd1;
            state_in = ST_MULA;
            case (step_ff)
               STEP_X: begin px_in = rnd[19:0]; acc_in = '0; end
               STEP_Y: begin py_in = rnd[19:0]; acc_in = '0; end
               STEP_Z: begin pz_in = rnd[19:0]; acc_in = '0; end
               STEP_W: begin pw_in = rnd[19:0]; acc_in = '0; end
               STEP_A: begin a_in = sum2[43:0]; acc_in = '0; end
               STEP_B: begin
                  b_in   = 44'(ONE_Q28 + sum2);
                  acc_in = '0;
               end
               STEP_S: begin
                  if (sum2 > ONE_Q28) begin
                     s_in = 30'(ONE_Q28);
                  end else if (sum2 < -ONE_Q28) begin
                     s_in = 30'(-ONE_Q28);
                  end else begin
                     s_in = sum2[29:0];
                  end
                  acc_in = '0;
               end
               LAST_STEP: begin
                  rad_in   = 58'(ONE_Q56 + 61'(sum));
                  root_in  = '0;
                  bit_in   = 58'd1 << 56;
                  state_in = ST_SQRT;
               end
               default: ;
            endcase
         end
         ST_SQRT: begin
            if (rad_ff >= trial) begin
               rad_in  = rad_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               pass_in  = 1'b0;
               state_in = ST_CINIT;
            end
         end
         ST_CINIT: begin
            iter_in = '0;
            if (xv < 0) begin
               if (yv >= 0) begin
                  cx_in = yv;
                  cy_in = -xv;
                  cz_in = Z90;
               end else begin
                  cx_in = -yv;
                  cy_in = xv;
                  cz_in = -Z90;
               end
            end else begin
               cx_in = xv;
               cy_in = yv;
               cz_in = '0;
            end
            state_in = ST_CORD;
         end
         ST_CORD: begin
            cx_in   = cx_nx;
            cy_in   = cy_nx;
            cz_in   = cz_nx;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_LAST) begin
               if (pass_ff) begin
                  pitch_in = zr[17:0];
                  state_in = ST_FIN;
               end else begin
                  roll_in  = zr[17:0];
                  pass_in  = 1'b1;
                  state_in = ST_CINIT;
               end
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (zero_ff) begin
                  rsp_pitch_in = '0;
                  rsp_roll_in  = '0;
               end else begin
                  rsp_pitch_in = dead_gain(p_sel, cfg.deadzone_q8, cfg.gain_q8,
                                           !cfg.invert_x);
                  rsp_roll_in  = dead_gain(r_sel, cfg.deadzone_q8, cfg.gain_q8,
                                           cfg.invert_z);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      zero_ff      <= zero_in;
      step_ff      <= step_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      pz_ff        <= pz_in;
      pw_ff        <= pw_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      s_ff         <= s_in;
      rad_ff       <= rad_in;
      root_ff      <= root_in;
      bit_ff       <= bit_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      cz_ff        <= cz_in;
      iter_ff      <= iter_in;
      pass_ff      <= pass_in;
      roll_ff      <= roll_in;
      pitch_ff     <= pitch_in;
      rsp_pitch_ff <= rsp_pitch_in;
      rsp_roll_ff  <= rsp_roll_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_cord_iter: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORD) |-> (iter_ff <= ITER_LAST)) else $error("cordic overran");
   a_sqrt_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT) |-> $onehot(bit_ff)) else $error("sqrt bit lost");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULA) |-> (step_ff <= LAST_STEP)) else $error("step overran");
   a_fin_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not registered");

endmodule

/* src/quaternion_tilt_to_pitch_roll_unit.sv */
// ----------------------------------------------------------------------------
// quaternion_tilt_to_pitch_roll_unit
// Orientation quaternion to pitch/roll tilt with recentre, deadzone and gain.
// ----------------------------------------------------------------------------
// A connected request passes through the back end in order: taking it from
// the queue, the 23 products on the single shared multiplier, the bit-serial
// square root, two passes of the 16-step CORDIC and registering the output
// once the output register is free. A request from a disconnected pad goes
// straight from taking it to registering the output. The queue registers each
// request before the back end sees it. The front end and a two-entry queue
// take up to two further requests while one is worked on, and the output
// register holds a result until the response is taken.
module quaternion_tilt_to_pitch_roll_unit import qtpr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [15:0]  req_quat_x,
   input  logic signed [15:0]  req_quat_y,
   input  logic signed [15:0]  req_quat_z,
   input  logic signed [15:0]  req_quat_w,
   input  logic                req_pad_connected,
   input  logic                req_touch_pressed,
   input  logic                req_recentre_request,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [18:0]  rsp_pitch_out,
   output logic signed [18:0]  rsp_roll_out,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   qtpr_job_type front_job, back_job;
   logic         front_valid, front_ready, back_valid, back_ready;
   qtpr_cfg_type cfg_ff, cfg_in;
   logic         wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[4:2])
            REG_AXIS_SWAP: cfg_in.axis_swap   = pwdata[0];
            REG_INVERT_X:  cfg_in.invert_x    = pwdata[0];
            REG_INVERT_Z:  cfg_in.invert_z    = pwdata[0];
            REG_GAIN:      cfg_in.gain_q8     = pwdata[9:0];
            REG_DEADZONE:  cfg_in.deadzone_q8 = pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_AXIS_SWAP: prdata = {31'b0, cfg_ff.axis_swap};
         REG_INVERT_X:  prdata = {31'b0, cfg_ff.invert_x};
         REG_INVERT_Z:  prdata = {31'b0, cfg_ff.invert_z};
         REG_GAIN:      prdata = {22'b0, cfg_ff.gain_q8};
         REG_DEADZONE:  prdata = {17'b0, cfg_ff.deadzone_q8};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis_swap   <= 1'b1;
         cfg_ff.invert_x    <= 1'b0;
         cfg_ff.invert_z    <= 1'b0;
         cfg_ff.gain_q8     <= 10'd179;
         cfg_ff.deadzone_q8 <= 15'd640;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   qtpr_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_quat_x           (req_quat_x),
      .req_quat_y           (req_quat_y),
      .req_quat_z           (req_quat_z),
      .req_quat_w           (req_quat_w),
      .req_pad_connected    (req_pad_connected),
      .req_touch_pressed    (req_touch_pressed),
      .req_recentre_request (req_recentre_request),
      .job_valid            (front_valid),
      .job_ready            (front_ready),
      .job                  (front_job)
   );

   qtpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_job    (front_job),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_job   (back_job)
   );

   qtpr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (back_valid),
      .job_ready     (back_ready),
      .job           (back_job),
      .cfg           (cfg_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pitch_out (rsp_pitch_out),
      .rsp_roll_out  (rsp_roll_out)
   );

endmodule

/* test/tilt_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tilt_checker
// Watches the request and response channels of the tilt unit, predicts each
// response from its own copy of the level reference, button state and
// settings, and compares pitch and roll in order of arrival.
// ----------------------------------------------------------------------------
module tilt_checker import qtpr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   input  logic               req_pad_connected,
   input  logic               req_touch_pressed,
   input  logic               req_recentre_request,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [18:0] rsp_pitch_out,
   input  logic signed [18:0] rsp_roll_out,
   input  logic               cfg_we,
   input  logic [2:0]         cfg_idx,
   input  logic [31:0]        cfg_data,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      logic signed [18:0] pitch;
      logic signed [18:0] roll;
   } tilt_type;

   tilt_type      tilt_queue[$];
   longint        lvl[4];
   logic          btn_prev;
   qtpr_cfg_type  cfg;

   function automatic longint root56(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic longint angle_q8(longint yv, longint xv);
      longint x, y, z, dx, dy;
      x = xv; y = yv; z = 0;
      if (x < 0) begin
         if (y >= 0) begin
            x = yv; y = -xv; z = 90 <<< 16;
         end else begin
            x = -yv; y = xv; z = -(90 <<< 16);
         end
      end
      for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += longint'(atan_q16(ITER_W'(i)));
         end else begin
            x -= dx; y += dy; z -= longint'(atan_q16(ITER_W'(i)));
         end
      end
      return (z + 128) >>> 8;
   endfunction

   function automatic logic signed [18:0] shape(longint v, logic neg);
      longint d, r;
      d = cfg.deadzone_q8;
      if (v > d) v -= d;
      else if (v < -d) v += d;
      else v = 0;
      r = (v * longint'(cfg.gain_q8) + 128) >>> 8;
      return neg ? 19'(-r) : 19'(r);
   endfunction

   function automatic tilt_type predict_tilt(longint qx, longint qy, longint qz,
                                             longint qw, logic touch, logic rec);
      tilt_type t;
      longint nx, ny, nz, aw, x, y, z, w, a, b, s, c, roll, pitch, tmp;
      if ((touch && !btn_prev) || rec) begin
         lvl[0] = qx; lvl[1] = qy; lvl[2] = qz; lvl[3] = qw;
      end
      btn_prev = touch;
      nx = -lvl[0]; ny = -lvl[1]; nz = -lvl[2]; aw = lvl[3];
      x = (aw * qx + nx * qw + ny * qz - nz * qy + 8192) >>> 14;
      y = (aw * qy - nx * qz + ny * qw + nz * qx + 8192) >>> 14;
      z = (aw * qz + nx * qy - ny * qx + nz * qw + 8192) >>> 14;
      w = (aw * qw - nx * qx - ny * qy - nz * qz + 8192) >>> 14;
      a = 2 * (w * x + y * z);
      b = (64'sd1 <<< 28) - 2 * (x * x + y * y);
      roll = angle_q8(a, b);
      s = 2 * (w * y - z * x);
      if (s > (64'sd1 <<< 28)) s = 64'sd1 <<< 28;
      if (s < -(64'sd1 <<< 28)) s = -(64'sd1 <<< 28);
      c = root56((64'sd1 <<< 56) - s * s);
      pitch = angle_q8(s, c);
      if (cfg.axis_swap) begin
         tmp = pitch; pitch = roll; roll = tmp;
      end
      t.pitch = shape(pitch, cfg.invert_x == 1'b0);
      t.roll  = shape(roll, cfg.invert_z);
      return t;
   endfunction

   always_ff @(posedge clock) begin
      tilt_type t, got;
      int       errs;
      errs = 0;
      if (reset) begin
         lvl = '{0, 0, 0, 16384};
         btn_prev = 1'b0;
         cfg <= '{axis_swap: 1'b1, invert_x: 1'b0, invert_z: 1'b0,
                  gain_q8: 10'd179, deadzone_q8: 15'd640};
         tilt_queue.delete();
         fail_count <= 0;
      end else begin
         if (cfg_we) begin
            case (cfg_idx)
               REG_AXIS_SWAP: cfg.axis_swap   <= cfg_data[0];
               REG_INVERT_X:  cfg.invert_x    <= cfg_data[0];
               REG_INVERT_Z:  cfg.invert_z    <= cfg_data[0];
               REG_GAIN:      cfg.gain_q8     <= cfg_data[9:0];
               REG_DEADZONE:  cfg.deadzone_q8 <= cfg_data[14:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_pad_connected)
               t = predict_tilt(req_quat_x, req_quat_y, req_quat_z, req_quat_w,
                                req_touch_pressed, req_recentre_request);
            else
               t = '0;
            tilt_queue.push_back(t);
         end
         if (rsp_valid && rsp_ready) begin
            got.pitch = rsp_pitch_out;
            got.roll  = rsp_roll_out;
            if (tilt_queue.size() == 0) begin
               $error("unexpected response pitch %0d roll %0d", got.pitch, got.roll);
               errs++;
            end else begin
               t = tilt_queue.pop_front();
               if (got.pitch !== t.pitch) begin
                  $error("pitch_out expected %0d actual %0d", t.pitch, got.pitch);
                  errs++;
               end
               if (got.roll !== t.roll) begin
                  $error("roll_out expected %0d actual %0d", t.roll, got.roll);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
      pending = tilt_queue.size();
   end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the tilt unit: register sweeps over APB, directed quaternion
// corner cases, then random recentre sequences with idle gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;
   import qtpr_pkg::*;

   localparam int WATCHDOG = 20000;

   logic               clock, reset;
   logic               req_valid, req_ready;
   logic signed [15:0] req_quat_x, req_quat_y, req_quat_z, req_quat_w;
   logic               req_pad_connected, req_touch_pressed, req_recentre_request;
   logic               rsp_valid, rsp_ready;
   logic signed [18:0] rsp_pitch_out, rsp_roll_out;
   logic               psel, penable, pwrite, pready;
   logic [ADDR_W-1:0]  paddr;
   logic [31:0]        pwdata, prdata;
   int                 fail_count, pending, idle_cycles, sent, rsp_hold;
   logic               rsp_random;

   quaternion_tilt_to_pitch_roll_unit dut (.*);

   tilt_checker checker_inst (
      .clock, .reset, .req_valid, .req_ready, .req_quat_x, .req_quat_y,
      .req_quat_z, .req_quat_w, .req_pad_connected, .req_touch_pressed,
      .req_recentre_request, .rsp_valid, .rsp_ready, .rsp_pitch_out,
      .rsp_roll_out, .cfg_we(psel && penable && pwrite && pready),
      .cfg_idx(3'(paddr >> 2)), .cfg_data(pwdata), .fail_count, .pending);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (!rsp_random) begin
         rsp_ready <= 1'b1;
      end else if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else if ($urandom_range(0, 999) < 5) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= $urandom_range(20, 150);
      end else begin
         rsp_ready <= ($urandom_range(0, 99) < 8) ? 1'b0 :
                      ($urandom_range(0, 3) != 0);
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= ADDR_W'(idx) << 2; pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   // valid stays high after an accept so that a back-to-back request
   // replaces it at the same falling edge
   task automatic send(input logic signed [15:0] x, y, z, w,
                       input logic conn, touch, rec);
      int n;
      n = gap_len();
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_quat_x <= x; req_quat_y <= y; req_quat_z <= z; req_quat_w <= w;
      req_pad_connected <= conn; req_touch_pressed <= touch;
      req_recentre_request <= rec;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic rand_quat(output logic signed [15:0] x, y, z, w);
      real a, b, c, d, n;
      if ($urandom_range(0, 9) == 0) begin
         x = 16'($urandom); y = 16'($urandom); z = 16'($urandom); w = 16'($urandom);
      end else begin
         a = $urandom_range(0, 2000) - 1000.0; b = $urandom_range(0, 2000) - 1000.0;
         c = $urandom_range(0, 2000) - 1000.0; d = $urandom_range(0, 2000) - 1000.0;
         n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
         x = 16'($rtoi(16384.0 * a / n)); y = 16'($rtoi(16384.0 * b / n));
         z = 16'($rtoi(16384.0 * c / n)); w = 16'($rtoi(16384.0 * d / n));
      end
   endtask

   initial begin
      logic signed [15:0] x, y, z, w;
      logic touch;
      reset = 1'b1;
      req_valid = 0; req_quat_x = 0; req_quat_y = 0; req_quat_z = 0; req_quat_w = 0;
      req_pad_connected = 0; req_touch_pressed = 0; req_recentre_request = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      rsp_random = 1'b0; sent = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send(0, 0, 0, 16384, 1, 0, 0);
      send(0, 0, 0, 0, 1, 0, 0);
      send(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1, 0, 0);
      send(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1, 0, 0);
      send(16384, 0, 0, 0, 1, 0, 0);
      send(0, 16384, 0, 0, 1, 0, 0);
      send(0, 0, 16384, 0, 1, 0, 0);
      send(11585, 0, 0, 11585, 1, 0, 0);
      send(0, 11585, 0, 11585, 1, 0, 0);
      send(1234, -4321, 777, 9000, 0, 1, 1);
      send(3000, 2000, 1000, 15000, 1, 1, 0);
      send(3000, 2000, 1000, 15000, 1, 1, 0);
      send(-5000, 800, -300, 15000, 1, 0, 1);
      send(-5000, 800, -300, 15000, 1, 1, 1);
      send(0, 0, 0, 16384, 1, 0, 1);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               csr_write(REG_AXIS_SWAP, 0); csr_write(REG_INVERT_X, 1);
               csr_write(REG_INVERT_Z, 1); csr_write(REG_GAIN, 1023);
               csr_write(REG_DEADZONE, 0);
            end
            1: begin
               csr_write(REG_GAIN, 0); csr_write(REG_DEADZONE, 23040);
            end
            2: begin
               csr_write(REG_AXIS_SWAP, 32'hffff_fffe); csr_write(REG_GAIN, 256);
               csr_write(REG_DEADZONE, 32'hffff_8000); csr_write(5, 32'h1234);
            end
            default: begin
               csr_write(REG_AXIS_SWAP, $urandom); csr_write(REG_INVERT_X, $urandom);
               csr_write(REG_INVERT_Z, $urandom); csr_write(REG_GAIN, $urandom);
               csr_write(REG_DEADZONE, $urandom_range(0, 32767));
            end
         endcase
         rsp_random = (ph != 1);
         touch = 1'b0;
         for (int k = 0; k < 150; k++) begin
            rand_quat(x, y, z, w);
            if ($urandom_range(0, 9) < 3) touch = ~touch;
            send(x, y, z, w, $urandom_range(0, 9) != 0, touch,
                 $urandom_range(0, 19) == 0);
            if (k == 75) drain();
         end
         drain();
      end

      $display("testbench: %0d requests over 7 register settings incl. extremes,", sent);
      $display("  recentre edges/requests, disconnected samples, random stalls");
      if (fail_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

/* sim.f */
src/qtpr_pkg.sv
src/qtpr_front.sv
src/qtpr_queue.sv
src/qtpr_back.sv
src/quaternion_tilt_to_pitch_roll_unit.sv
test/tilt_checker.sv
test/testbench.sv
